[sv/sefr_pkg.sv]
package sefr_pkg;

   localparam logic [7:0] START_BYTE = 8'h01;
   localparam logic [7:0] ESC_BYTE   = 8'h02;
   localparam logic [7:0] END_BYTE   = 8'h03;
   localparam logic [7:0] ESC_MASK   = 8'h10;

   localparam int unsigned COUNT_WIDTH = 17;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 17'h10000;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_CMD_HI = 3'd1,
      PH_CMD_LO = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_LEN_LO = 3'd4,
      PH_CSUM   = 3'd5,
      PH_DATA   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_CSUM   = 2'd1,
      ST_LENGTH = 2'd2,
      ST_HEADER = 2'd3
   } status_type;

   typedef struct packed {
      logic        valid;
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [15:0] command_word;
      logic [15:0] declared_length;
      status_type  frame_status;
      logic        frame_last;
   } result_type;

endpackage

[sv/sefr_if.sv]
interface sefr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sefr_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  payload_byte;
   logic [15:0] command_word;
   logic [15:0] declared_length;
   logic [1:0]  frame_status;
   logic        frame_last;

   modport source (
      output valid, output item_kind, output payload_byte, output command_word,
      output declared_length, output frame_status, output frame_last, input ready
   );
   modport sink (
      input valid, input item_kind, input payload_byte, input command_word,
      input declared_length, input frame_status, input frame_last, output ready
   );
endinterface

[sv/sefr_parser.sv]
module sefr_parser
   import sefr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output result_type result
);

   phase_type              phase_ff, phase_in;
   logic                   escape_ff, escape_in;
   logic [15:0]            command_ff, command_in;
   logic [15:0]            length_ff, length_in;
   logic [7:0]             rx_csum_ff, rx_csum_in;
   logic [7:0]             data_xor_ff, data_xor_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [7:0] plain_byte;
   logic [7:0] calc_csum;
   status_type status;

   assign plain_byte = escape_ff ? (byte_data ^ ESC_MASK) : byte_data;
   assign calc_csum  = command_ff[15:8] ^ command_ff[7:0] ^ length_ff[15:8] ^
                       length_ff[7:0] ^ data_xor_ff;

   always_comb begin
      if (phase_ff != PH_DATA) begin
         status = ST_HEADER;
      end else if (count_ff != {1'b0, length_ff}) begin
         status = ST_LENGTH;
      end else if (calc_csum != rx_csum_ff) begin
         status = ST_CSUM;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      escape_in   = escape_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      rx_csum_in  = rx_csum_ff;
      data_xor_in = data_xor_ff;
      count_in    = count_ff;
      result      = '0;
      if (byte_valid) begin
         case (byte_data)
            START_BYTE: begin
               phase_in    = PH_CMD_HI;
               escape_in   = 1'b0;
               command_in  = '0;
               length_in   = '0;
               rx_csum_in  = '0;
               data_xor_in = '0;
               count_in    = '0;
            end
            ESC_BYTE: begin
               escape_in = 1'b1;
            end
            END_BYTE: begin
               escape_in = 1'b0;
               case (phase_ff)
                  PH_CMD_HI, PH_CMD_LO, PH_LEN_HI, PH_LEN_LO, PH_CSUM, PH_DATA: begin
                     phase_in               = PH_IDLE;
                     result.valid           = 1'b1;
                     result.item_kind       = KIND_REPORT;
                     result.command_word    = command_ff;
                     result.declared_length = length_ff;
                     result.frame_status    = status;
                     result.frame_last      = 1'b1;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               escape_in = 1'b0;
               case (phase_ff)
                  PH_CMD_HI: begin
                     command_in = {plain_byte, 8'h00};
                     phase_in   = PH_CMD_LO;
                  end
                  PH_CMD_LO: begin
                     command_in = {command_ff[15:8], plain_byte};
                     phase_in   = PH_LEN_HI;
                  end
                  PH_LEN_HI: begin
                     length_in = {plain_byte, 8'h00};
                     phase_in  = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     length_in = {length_ff[15:8], plain_byte};
                     phase_in  = PH_CSUM;
                  end
                  PH_CSUM: begin
                     rx_csum_in = plain_byte;
                     phase_in   = PH_DATA;
                  end
                  PH_DATA: begin
                     data_xor_in = data_xor_ff ^ plain_byte;
                     if (count_ff != COUNT_MAX) begin
                        count_in = count_ff + 1'b1;
                     end
                     result.valid        = 1'b1;
                     result.item_kind    = KIND_DATA;
                     result.payload_byte = plain_byte;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         escape_ff   <= 1'b0;
         command_ff  <= '0;
         length_ff   <= '0;
         rx_csum_ff  <= '0;
         data_xor_ff <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         escape_ff   <= escape_in;
         command_ff  <= command_in;
         length_ff   <= length_in;
         rx_csum_ff  <= rx_csum_in;
         data_xor_ff <= data_xor_in;
         count_ff    <= count_in;
      end
   end

endmodule

[sv/sefr_out_reg.sv]
module sefr_out_reg
   import sefr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       can_load,
   sefr_rsp_if.source rsp
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load && result.valid) begin
         data_ff <= result;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.item_kind       = data_ff.item_kind;
   assign rsp.payload_byte    = data_ff.payload_byte;
   assign rsp.command_word    = data_ff.command_word;
   assign rsp.declared_length = data_ff.declared_length;
   assign rsp.frame_status    = data_ff.frame_status;
   assign rsp.frame_last      = data_ff.frame_last;

endmodule

[sv/escaped_serial_frame_receiver_top.sv]
// a taken byte is held in the input register, and its result in the result register, before rsp offers it
// throughput: one byte per cycle unless the result register stalls; an input register feeds
// the frame parser, whose combinational output loads the result register
// a stalled result register holds the input register and then req ready
// reset (synchronous, active high) returns the parser to idle and empties both registers
module escaped_serial_frame_receiver_top
   import sefr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sefr_req_if.sink   req_chan,
   sefr_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       can_load;
   result_type result;

   assign advance        = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || can_load;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   sefr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (advance),
      .byte_data  (in_byte_ff),
      .result     (result)
   );

   sefr_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && rsp_chan.valid && !rsp_chan.ready)
      else $error("input blocked without a stalled result");

   a_result_from_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(in_valid_ff))
      else $error("result appeared without a buffered byte");

   a_held_byte_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !can_load |=> in_valid_ff && $stable(in_byte_ff))
      else $error("buffered byte lost while output stalled");

   a_report_marks_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.item_kind == rsp_chan.frame_last))
      else $error("report and last flag disagree");

endmodule
